// ===== rtl/otcpl_pkg.sv =====
// Shared types, sizes and codes of the offset tree child and parent lookup.
package otcpl_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int NODE_BITS     = 20;
   localparam int MAX_CHILDREN  = 64;

   localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS  = $clog2(MAX_CHILDREN + 1);
   localparam int CMD_BITS  = 2;
   localparam int STAT_BITS = 3;
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_LOAD     = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CHILDREN = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_PARENT   = 2'd2;

   // Status codes.
   localparam logic [STAT_BITS-1:0] ST_OK    = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_NONE  = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_RANGE = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_ROOT  = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_TRUNC = 3'd4;

   // Register index of range_count.
   localparam logic REG_RANGE_COUNT = 1'b0;

   typedef struct packed {
      logic [CMD_BITS-1:0]  cmd;
      logic [IDX_BITS-1:0]  entry_index;
      logic [NODE_BITS-1:0] entry_value;
      logic [NODE_BITS-1:0] query_node;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] answer_node;
      logic [STAT_BITS-1:0] status;
      logic                 last;
   } rsp_type;

endpackage

// ===== rtl/offset_tree_child_parent_lookup.sv =====
// Offset tree lookup: a table of first-child offsets answers children and parent queries.
// The block holds a 4096-entry table of first-child offsets in a memory with one write port
// and one registered read port, and a small sequencer drives every query through that one
// read port. A load beat writes the table in the cycle in which it is accepted. A children
// query reads the node count and the two bounding offsets, then gives one result beat per
// cycle while the output is taken. A parent query reads the node count and the first entry,
// then scans the table one entry per cycle until the first entry above the node is found
// or the scan reaches range_count. A node at or beyond the node count gets a range status
// with no further table read. A waiting result sits in an output register, so the next
// query is taken while it is still unread.
module offset_tree_child_parent_lookup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  otcpl_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output otcpl_pkg::rsp_type                  rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [otcpl_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [otcpl_pkg::DATA_BITS-1:0]     pwdata,
   output logic [otcpl_pkg::DATA_BITS-1:0]     prdata,
   output logic                                pready
);

   localparam int IB = otcpl_pkg::IDX_BITS;
   localparam int NB = otcpl_pkg::NODE_BITS;
   localparam int CB = otcpl_pkg::CNT_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SIZE  = 3'd1;
   localparam logic [2:0] S_BEGIN = 3'd2;
   localparam logic [2:0] S_END   = 3'd3;
   localparam logic [2:0] S_RUN   = 3'd4;
   localparam logic [2:0] S_ROOT0 = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [NB-1:0] table_mem [otcpl_pkg::TABLE_ENTRIES];
   logic [NB-1:0] rd_data_ff;
   logic [IB-1:0] rd_addr;
   logic          mem_we;

   logic [2:0]    state_ff, state_in;
   logic [IB-1:0] range_count_ff;
   logic [NB-1:0] node_ff, node_in;
   logic          parent_ff, parent_in;
   logic [NB-1:0] begin_ff, begin_in;
   logic [NB-1:0] end_ff, end_in;
   logic [NB-1:0] cur_ff, cur_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          trunc_ff, trunc_in;
   logic [NB-1:0] first_ff, first_in;
   logic [IB-1:0] chk_ff, chk_in;
   logic [otcpl_pkg::STAT_BITS-1:0] pend_st_ff, pend_st_in;
   logic [NB-1:0] pend_ans_ff, pend_ans_in;
   otcpl_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          out_free;
   logic          run_last;
   logic [NB-1:0] run_len;
   logic          csr_write;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign run_last  = !trunc_ff && ((cur_ff + NB'(1)) == end_ff);
   assign run_len   = rd_data_ff - begin_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == otcpl_pkg::REG_RANGE_COUNT);
   assign prdata    = (paddr[2] == otcpl_pkg::REG_RANGE_COUNT)
                      ? otcpl_pkg::DATA_BITS'(range_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
      end else if (csr_write) begin
         range_count_ff <= pwdata[IB-1:0];
      end
   end

   // Offset table.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[req_data.entry_index] <= req_data.entry_value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      parent_in    = parent_ff;
      begin_in     = begin_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      trunc_in     = trunc_ff;
      first_in     = first_ff;
      chk_in       = chk_ff;
      pend_st_in   = pend_st_ff;
      pend_ans_in  = pend_ans_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = '0;
      mem_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            rd_addr = range_count_ff;
            if (req_valid) begin
               if (req_data.cmd == otcpl_pkg::CMD_LOAD) begin
                  mem_we = 1'b1;
               end else if (req_data.cmd == otcpl_pkg::CMD_CHILDREN ||
                            req_data.cmd == otcpl_pkg::CMD_PARENT) begin
                  node_in   = req_data.query_node;
                  parent_in = (req_data.cmd == otcpl_pkg::CMD_PARENT);
                  state_in  = S_SIZE;
               end
            end
         end
         S_SIZE: begin
            // The read data holds the node count, entry[range_count].
            rd_addr     = parent_ff ? '0 : node_ff[IB-1:0];
            pend_ans_in = '0;
            if (node_ff >= rd_data_ff) begin
               pend_st_in = otcpl_pkg::ST_RANGE;
               state_in   = S_EMIT;
            end else if (parent_ff) begin
               state_in = S_ROOT0;
            end else if (node_ff >= NB'(range_count_ff)) begin
               pend_st_in = otcpl_pkg::ST_NONE;
               state_in   = S_EMIT;
            end else begin
               state_in = S_BEGIN;
            end
         end
         S_BEGIN: begin
            begin_in = rd_data_ff;
            rd_addr  = node_ff[IB-1:0] + IB'(1);
            state_in = S_END;
         end
         S_END: begin
            if (rd_data_ff <= begin_ff) begin
               pend_st_in  = otcpl_pkg::ST_NONE;
               pend_ans_in = '0;
               state_in    = S_EMIT;
            end else begin
               end_in   = rd_data_ff;
               cur_in   = begin_ff;
               cnt_in   = '0;
               trunc_in = run_len > NB'(otcpl_pkg::MAX_CHILDREN);
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (trunc_ff && cnt_ff == CB'(otcpl_pkg::MAX_CHILDREN - 1)) begin
                  rsp_in.answer_node = '0;
                  rsp_in.status      = otcpl_pkg::ST_TRUNC;
                  rsp_in.last        = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  rsp_in.answer_node = cur_ff;
                  rsp_in.status      = otcpl_pkg::ST_OK;
                  rsp_in.last        = run_last;
                  cur_in             = cur_ff + NB'(1);
                  cnt_in             = cnt_ff + CB'(1);
                  if (run_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_ROOT0: begin
            first_in    = rd_data_ff;
            rd_addr     = IB'(1);
            chk_in      = '0;
            pend_ans_in = '0;
            if (range_count_ff == '0) begin
               pend_st_in = otcpl_pkg::ST_ROOT;
               state_in   = S_EMIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // The read data is entry[chk+1]; the read for the next step is already issued.
            rd_addr = chk_ff + IB'(2);
            if (rd_data_ff > node_ff) begin
               // Earlier entries were all at or below the node, so only entry 0 needs a check.
               if (chk_ff == '0 && first_ff > node_ff) begin
                  pend_st_in  = otcpl_pkg::ST_ROOT;
                  pend_ans_in = '0;
               end else begin
                  pend_st_in  = otcpl_pkg::ST_OK;
                  pend_ans_in = NB'(chk_ff);
               end
               state_in = S_EMIT;
            end else if ((chk_ff + IB'(1)) == range_count_ff) begin
               pend_st_in  = otcpl_pkg::ST_ROOT;
               pend_ans_in = '0;
               state_in    = S_EMIT;
            end else begin
               chk_in = chk_ff + IB'(1);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.answer_node = pend_ans_ff;
               rsp_in.status      = pend_st_ff;
               rsp_in.last        = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      parent_ff   <= parent_in;
      begin_ff    <= begin_in;
      end_ff      <= end_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      trunc_ff    <= trunc_in;
      first_ff    <= first_in;
      chk_ff      <= chk_in;
      pend_st_ff  <= pend_st_in;
      pend_ans_ff <= pend_ans_in;
      rsp_ff      <= rsp_in;
   end

   // A query keeps the input side closed for at least the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.cmd == otcpl_pkg::CMD_CHILDREN ||
                                  req_data.cmd == otcpl_pkg::CMD_PARENT)) |=> !req_ready)
      else $error("input accepted right after a query");

   // Only an ok result carries a node index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != otcpl_pkg::ST_OK) |-> (rsp_data.answer_node == '0))
      else $error("non-ok result carries a node index");

   // Every status other than ok closes the query.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != otcpl_pkg::ST_OK) |-> rsp_data.last)
      else $error("non-ok result without last mark");

   // A run in progress never leaves the input side open.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |-> !req_ready)
      else $error("input open in the middle of a run");

endmodule
